// ----- sv/ipr_pkg.sv -----
// Package for the integer pixel replicator: field widths, payload structs,
// configuration register codes and the front-to-back queue entry.
// No dependencies.
package ipr_pkg;

  localparam int MaxScaleDef   = 4;
  localparam int BaseWidthDef  = 320;
  localparam int BaseHeightDef = 200;
  localparam int QueueDepthDef = 2;

  localparam int XW       = 9;
  localparam int YW       = 8;
  localparam int PixW     = 8;
  localparam int AddrW    = 20;
  localparam int ScaleRegW = 3;
  // Covers every replication factor up to 15, beyond the 3-bit scale register
  localparam int EScaleW  = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    RegScale   = 3'd0,
    RegWinEn   = 3'd1,
    RegWinX    = 3'd2,
    RegWinY    = 3'd3,
    RegWinW    = 3'd4,
    RegWinH    = 3'd5,
    RegMode    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [XW-1:0]   pixel_x;
    logic [YW-1:0]   pixel_y;
    logic [PixW-1:0] source_pixel;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] native_address;
    logic [PixW-1:0]  native_pixel;
    logic             last_write;
  } out_item_t;

  typedef struct packed {
    logic [ScaleRegW-1:0] scale;
    logic                 window_enable;
    logic [XW-1:0]        window_x;
    logic [YW-1:0]        window_y;
    logic [XW-1:0]        window_w;
    logic [YW-1:0]        window_h;
    logic                 compose_mode;
  } cfg_t;

  // One block of writes: scaled row and column, replication factor, value
  typedef struct packed {
    logic [YW+EScaleW-1:0] row_s;
    logic [XW+EScaleW-1:0] col_s;
    logic [EScaleW-1:0]    scale;
    logic [PixW-1:0]       pixel;
  } blk_t;

endpackage

// ----- sv/integer_pixel_replicate_compose_top.sv -----
// Top level of the integer pixel replicator: configuration registers and the
// front end, queue and back end. Uses ipr_pkg, ipr_front, ipr_queue, ipr_back.
//
// Usage: each input request carries one logical pixel (column, row, value).
// A pixel that is off screen, or that the window and compose mode reject, is
// taken and produces nothing. Otherwise it expands into scale x scale native
// write requests, row-major, the final one flagged by last_write. Addresses
// use a row stride of BASE_WIDTH*MAX_SCALE and wrap at 20 bits.
// The back end issues one write per cycle while the receiver does not
// stall; a rejected pixel is taken and writes nothing. The first write
// passes the queue, the back end's block registers and the output register.
// A two-entry queue lets the input side keep accepting while the back end
// works or the receiver stalls; a stalled output holds its request and the
// input stalls only once the queue is full.
// Configuration writes are always taken and must be issued only while the
// block is idle. Reset sets scale to 1, clears all other registers and
// empties the queue and output.
module integer_pixel_replicate_compose_top import ipr_pkg::*; #(
  parameter int MAX_SCALE   = MaxScaleDef,
  parameter int BASE_WIDTH  = BaseWidthDef,
  parameter int BASE_HEIGHT = BaseHeightDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic push_valid;
  logic push_ready;
  blk_t push_data;
  logic pop_valid;
  logic pop_ready;
  blk_t pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      cfg_q.scale <= ScaleRegW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegScale: cfg_q.scale         <= cfg_data_i[ScaleRegW-1:0];
        RegWinEn: cfg_q.window_enable <= cfg_data_i[0];
        RegWinX:  cfg_q.window_x      <= cfg_data_i[XW-1:0];
        RegWinY:  cfg_q.window_y      <= cfg_data_i[YW-1:0];
        RegWinW:  cfg_q.window_w      <= cfg_data_i[XW-1:0];
        RegWinH:  cfg_q.window_h      <= cfg_data_i[YW-1:0];
        RegMode:  cfg_q.compose_mode  <= cfg_data_i[0];
        default:  cfg_q               <= cfg_q;
      endcase
    end
  end

  ipr_front #(
    .MAX_SCALE   (MAX_SCALE),
    .BASE_WIDTH  (BASE_WIDTH),
    .BASE_HEIGHT (BASE_HEIGHT)
  ) u_front (
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ipr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ipr_back #(
    .MAX_SCALE  (MAX_SCALE),
    .BASE_WIDTH (BASE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sv/ipr_front.sv -----
// Front end: takes a logical pixel request, decides whether it writes,
// and pushes a scaled block descriptor into the queue. Uses ipr_pkg.
module ipr_front import ipr_pkg::*; #(
  parameter int MAX_SCALE   = MaxScaleDef,
  parameter int BASE_WIDTH  = BaseWidthDef,
  parameter int BASE_HEIGHT = BaseHeightDef
) (
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output blk_t     push_data_o
);

  localparam logic [EScaleW-1:0] MaxS  = EScaleW'(MAX_SCALE);
  localparam logic [10:0]        BaseW = 11'(BASE_WIDTH);
  localparam logic [10:0]        BaseH = 11'(BASE_HEIGHT);

  logic [EScaleW-1:0] s_raw;
  logic [EScaleW-1:0] s_eff;
  logic               on_screen;
  logic [XW:0]        x_end;
  logic [YW:0]        y_end;
  logic               in_window;
  logic               emit;

  always_comb begin
    s_raw = EScaleW'(cfg_i.scale);
    if (s_raw == '0) begin
      s_eff = EScaleW'(1);
    end else if (s_raw > MaxS) begin
      s_eff = MaxS;
    end else begin
      s_eff = s_raw;
    end
  end

  assign on_screen = ({2'b00, in_item_i.pixel_x} < BaseW) &&
                     ({3'b000, in_item_i.pixel_y} < BaseH);

  // Window edges computed one bit wider so they never wrap
  assign x_end     = {1'b0, cfg_i.window_x} + {1'b0, cfg_i.window_w};
  assign y_end     = {1'b0, cfg_i.window_y} + {1'b0, cfg_i.window_h};
  assign in_window = cfg_i.window_enable &&
                     (in_item_i.pixel_x >= cfg_i.window_x) &&
                     ({1'b0, in_item_i.pixel_x} < x_end) &&
                     (in_item_i.pixel_y >= cfg_i.window_y) &&
                     ({1'b0, in_item_i.pixel_y} < y_end);

  assign emit = on_screen &&
                (cfg_i.compose_mode ? (in_window && (in_item_i.source_pixel != '0))
                                    : !in_window);

  // Dropped pixels are taken without a push
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && emit;

  always_comb begin
    push_data_o.row_s = (YW+EScaleW)'(in_item_i.pixel_y) * (YW+EScaleW)'(s_eff);
    push_data_o.col_s = (XW+EScaleW)'(in_item_i.pixel_x) * (XW+EScaleW)'(s_eff);
    push_data_o.scale = s_eff;
    push_data_o.pixel = in_item_i.source_pixel;
  end

endmodule

// ----- sv/ipr_queue.sv -----
// Short register queue of block descriptors between front and back end.
// Uses ipr_pkg for the entry type.
module ipr_queue import ipr_pkg::*; #(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  blk_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output blk_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  blk_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/ipr_back.sv -----
// Back end: emits one native write request per cycle unless stalled,
// walking each block row by row into an output register. Uses ipr_pkg.
module ipr_back import ipr_pkg::*; #(
  parameter int MAX_SCALE  = MaxScaleDef,
  parameter int BASE_WIDTH = BaseWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  blk_t      pop_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [AddrW-1:0] Stride = AddrW'(BASE_WIDTH * MAX_SCALE);

  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [AddrW-1:0]   row_q, row_d;
  logic [EScaleW-1:0] dx_q, dx_d;
  logic [EScaleW-1:0] dy_q, dy_d;
  logic [EScaleW-1:0] scale_q, scale_d;
  logic [PixW-1:0]    pix_q, pix_d;
  logic [EScaleW-1:0] s_max;
  logic               step;
  logic               row_end;
  logic               last;
  logic               load;

  assign s_max   = scale_q - EScaleW'(1);
  assign step    = busy_q && (!out_valid_q || out_ready_i);
  assign row_end = (dx_q == s_max);
  assign last    = row_end && (dy_q == s_max);
  // Take the next block in the cycle the current one finishes
  assign pop_ready_o = !busy_q || (step && last);
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    busy_d  = busy_q;
    row_d   = row_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    scale_d = scale_q;
    pix_d   = pix_q;
    if (step) begin
      if (row_end) begin
        dx_d  = '0;
        dy_d  = dy_q + 1'b1;
        row_d = row_q + Stride;
      end else begin
        dx_d = dx_q + 1'b1;
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      row_d   = AddrW'(pop_data_i.row_s) * Stride + AddrW'(pop_data_i.col_s);
      dx_d    = '0;
      dy_d    = '0;
      scale_d = pop_data_i.scale;
      pix_d   = pop_data_i.pixel;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d          = 1'b1;
      out_d.native_address = row_q + AddrW'(dx_q);
      out_d.native_pixel   = pix_q;
      out_d.last_write     = last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    row_q   <= row_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    scale_q <= scale_d;
    pix_q   <= pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
